/* sv/b64w_pkg.sv */
// Shared types and constants for the line-wrapped base64 encoder.
// No dependencies; every other file of the block imports this package.
package b64w_pkg;

    localparam int LINE_LEN_W = 10;
    localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 10'd76;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // One group as handed from the front end to the character emitter.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       crlf;
        logic       fin;
    } b64w_grp_t;

    // Standard base64 alphabet, computed from the sextet value.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        priority if (v < 6'd26)
            r = 8'd65 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'd71 + {2'b00, v};
        else if (v < 6'd62)
            r = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

endpackage

/* sv/b64w_front.sv */
// Front end: gathers input bytes into groups of three and decides line breaks.
// Depends on b64w_pkg; writes finished groups into the group queue.
module b64w_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        data_byte,
    input  logic                              final_byte,
    input  logic [b64w_pkg::LINE_LEN_W-1:0]   line_length,
    output logic                              grp_push,
    output b64w_pkg::b64w_grp_t               grp
);
    import b64w_pkg::*;

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [7:0]  groups_reg, groups_next;
    logic [7:0]  groups_inc;
    logic        line_full;
    logic        completes;

    assign completes  = final_byte || (held_count_reg == 2'd2);
    assign groups_inc = groups_reg + 8'd1;
    // A counter that wraps to zero also ends the line.
    assign line_full  = (groups_inc >= line_length[LINE_LEN_W-1:2]) || (groups_inc == 8'd0);

    always_comb
    begin
        grp.b0     = held_bytes_reg[15:8];
        grp.b1     = held_bytes_reg[7:0];
        grp.b2     = data_byte;
        grp.nbytes = NBYTES_THREE;
        grp.crlf   = line_full || final_byte;
        grp.fin    = final_byte;
        unique case (held_count_reg)
            2'd0:
            begin
                grp.b0     = data_byte;
                grp.b1     = 8'd0;
                grp.b2     = 8'd0;
                grp.nbytes = NBYTES_ONE;
            end
            2'd1:
            begin
                grp.b1     = data_byte;
                grp.b2     = 8'd0;
                grp.nbytes = NBYTES_TWO;
            end
            default:
            begin
                grp.nbytes = NBYTES_THREE;
            end
        endcase
    end

    assign grp_push = accept && completes;

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        groups_next     = groups_reg;
        if (accept)
        begin
            if (completes)
            begin
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
                groups_next     = grp.crlf ? 8'd0 : groups_inc;
            end
            else if (held_count_reg == 2'd0)
            begin
                held_bytes_next = {data_byte, 8'd0};
                held_count_next = 2'd1;
            end
            else
            begin
                held_bytes_next = {held_bytes_reg[15:8], data_byte};
                held_count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'd0;
            held_count_reg <= 2'd0;
            groups_reg     <= 8'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            groups_reg     <= groups_next;
        end
    end

endmodule

/* sv/b64w_grpq.sv */
// Small group queue between the front end and the character emitter.
// Depends on b64w_pkg for the group type.
module b64w_grpq #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64w_pkg::b64w_grp_t wr_grp,
    input  logic                pop,
    output b64w_pkg::b64w_grp_t rd_grp,
    output logic                full,
    output logic                empty
);
    import b64w_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64w_grp_t         entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_grp  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= wr_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/b64w_back.sv */
// Character emitter: turns each queued group into base64 characters and CR LF.
// Depends on b64w_pkg; holds the result register seen on the output ports.
module b64w_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64w_pkg::b64w_grp_t grp,
    input  logic                grp_empty,
    output logic                grp_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_char,
    output logic                last_of_run,
    output logic                stream_done
);
    import b64w_pkg::*;

    localparam logic [2:0] POS_LAST_DATA = 3'd3;
    localparam logic [2:0] POS_LF        = 3'd5;

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       advance;
    logic       at_end;
    logic [7:0] cur_char;
    logic [5:0] s0, s1, s2, s3;

    assign s0 = grp.b0[7:2];
    assign s1 = {grp.b0[1:0], grp.b1[7:4]};
    assign s2 = {grp.b1[3:0], grp.b2[7:6]};
    assign s3 = grp.b2[5:0];

    always_comb
    begin
        unique case (pos_reg)
            3'd0:    cur_char = b64_char(s0);
            3'd1:    cur_char = b64_char(s1);
            3'd2:    cur_char = (grp.nbytes == NBYTES_ONE) ? CHAR_PAD : b64_char(s2);
            3'd3:    cur_char = (grp.nbytes == NBYTES_THREE) ? b64_char(s3) : CHAR_PAD;
            3'd4:    cur_char = CHAR_CR;
            default: cur_char = CHAR_LF;
        endcase
    end

    assign at_end  = grp.crlf ? (pos_reg == POS_LF) : (pos_reg == POS_LAST_DATA);
    // The result register reloads when it is empty or its beat leaves this cycle.
    assign advance = !valid_reg || pop;
    assign grp_pop = advance && !grp_empty && at_end;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (advance)
        begin
            valid_next = !grp_empty;
            if (!grp_empty)
            begin
                char_next = cur_char;
                last_next = at_end;
                done_next = at_end && grp.fin;
                pos_next  = at_end ? 3'd0 : pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign empty       = !valid_reg;
    assign out_char    = char_reg;
    assign last_of_run = last_reg;
    assign stream_done = done_reg;

endmodule

/* sv/base64_line_wrapped_encoder_core.sv */
// Top level of the base64 encoder with CR LF line wrapping.
// Depends on b64w_pkg, b64w_front, b64w_grpq and b64w_back.
//
//   channel   handshake              payload
//   input     push / full            data_byte[7:0], final_byte
//   result    empty / pop            out_char[7:0], last_of_run, stream_done
//   config    cfg_wr_en              cfg_wr_data[9:0] (line_length)
//
// One byte is taken per cycle while the group queue has room; the first character
// of a group goes through its queue entry and the result register to the ports.
// The emitter gives one character per cycle while pop is high, so throughput
// is set by the output: four characters per three bytes plus two per line break.
// Reset clears all held bytes, the line counter, the queue and the result register,
// and sets line_length to 76. A stalled result side fills the queue and raises full.
module base64_line_wrapped_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      data_byte,
    input  logic                            final_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_char,
    output logic                            last_of_run,
    output logic                            stream_done,
    input  logic                            cfg_wr_en,
    input  logic [b64w_pkg::LINE_LEN_W-1:0] cfg_wr_data
);
    import b64w_pkg::*;

    logic [LINE_LEN_W-1:0] line_length_reg;
    logic                  accept;
    logic                  grp_push;
    logic                  grp_pop;
    logic                  q_full;
    logic                  q_empty;
    b64w_grp_t             grp_in;
    b64w_grp_t             grp_head;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_length_reg <= LINE_LEN_RESET;
        else if (cfg_wr_en)
            line_length_reg <= cfg_wr_data;
    end

    b64w_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .line_length (line_length_reg),
        .grp_push    (grp_push),
        .grp         (grp_in)
    );

    b64w_grpq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_grpq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (grp_push),
        .wr_grp (grp_in),
        .pop    (grp_pop),
        .rd_grp (grp_head),
        .full   (q_full),
        .empty  (q_empty)
    );

    b64w_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp         (grp_head),
        .grp_empty   (q_empty),
        .grp_pop     (grp_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .stream_done (stream_done)
    );

    // The front end only writes a group when the queue has room for it.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        grp_push |-> !q_full)
        else $error("group written into a full queue");

    // The emitter only retires a group that is present.
    a_pop_present: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |-> !q_empty)
        else $error("group retired from an empty queue");

    // End of stream is always the last character of its byte's run.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_done) |-> last_of_run)
        else $error("stream_done without last_of_run");

    // A finished group leaving the queue means a run end was just loaded.
    a_retire_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |=> (!empty && last_of_run))
        else $error("retired group did not end its run");

endmodule

/* dv/base64_line_wrapped_encoder_core_test.sv */
// Self-checking testbench for base64_line_wrapped_encoder_core: bytes in, characters out.
// Depends on b64w_pkg and the core; a built-in predictor tracks grouping, padding and
// CR LF line breaks and checks every character beat against it.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_core_test;
    import b64w_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       stream_end;
    } enc_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            data_byte = 8'h00;
    logic                  final_byte = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            out_char;
    logic                  last_of_run;
    logic                  stream_done;
    logic                  cfg_wr_en = 1'b0;
    logic [LINE_LEN_W-1:0] cfg_wr_data = '0;

    // Predictor state.
    string            b64_table =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [9:0]       line_len_m;
    logic [15:0]      held_buf;
    logic [1:0]       held_cnt;
    logic [7:0]       grp_cnt;
    enc_char_t        pending_chars[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int chars_checked = 0;
    int streams_sent = 0;

    base64_line_wrapped_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .stream_done (stream_done),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return b64_table[v];
    endfunction

    // Works out the characters that one accepted byte causes.
    task automatic predict_beat(input logic [7:0] b, input logic fin);
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        int         nvalid;
        logic [7:0] chars[$];
        enc_char_t  c;
        if (held_cnt < 2 && !fin)
        begin
            if (held_cnt == 0)
                held_buf = {b, 8'h00};
            else
                held_buf[7:0] = b;
            held_cnt++;
            return;
        end
        if (held_cnt == 0)
        begin
            g0 = b; g1 = 8'h00; g2 = 8'h00; nvalid = 1;
        end
        else if (held_cnt == 1)
        begin
            g0 = held_buf[15:8]; g1 = b; g2 = 8'h00; nvalid = 2;
        end
        else
        begin
            g0 = held_buf[15:8]; g1 = held_buf[7:0]; g2 = b; nvalid = 3;
        end
        chars.push_back(sextet_char(g0[7:2]));
        chars.push_back(sextet_char({g0[1:0], g1[7:4]}));
        chars.push_back(nvalid > 1 ? sextet_char({g1[3:0], g2[7:6]}) : CHAR_PAD);
        chars.push_back(nvalid > 2 ? sextet_char(g2[5:0]) : CHAR_PAD);
        held_buf = '0;
        held_cnt = '0;
        grp_cnt = grp_cnt + 8'd1;
        // The 8-bit counter would wrap to zero only on the 256th group of a line.
        if (grp_cnt >= line_len_m[9:2] || grp_cnt == 8'd0 || fin)
        begin
            chars.push_back(CHAR_CR);
            chars.push_back(CHAR_LF);
            grp_cnt = '0;
        end
        foreach (chars[i])
        begin
            c.ch = chars[i];
            c.run_end = (i == chars.size() - 1);
            c.stream_end = c.run_end && fin;
            pending_chars.push_back(c);
        end
    endtask

    // Offers one byte and waits until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (full);
        predict_beat(b, fin);
        bytes_sent++;
        if (fin)
            streams_sent++;
    endtask

    task automatic send_random_stream(input int len);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), i == len - 1);
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_line_len(input logic [9:0] v);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        line_len_m = v;
    endtask

    // Pads, extremes of the byte range, the '+' and '/' characters, and streams that end
    // with zero, one or two bytes held, all at the reset line length.
    task automatic test_directed_groups();
        send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b1);
        send_beat(8'hA5, 1'b1);
        send_beat(8'h5A, 1'b0); send_beat(8'hFF, 1'b1);
        send_beat(8'hFB, 1'b0); send_beat(8'hEF, 1'b0); send_beat(8'hBE, 1'b1);
        send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b1);
    endtask

    // Line lengths below four break after every group; a full line on the last byte
    // must give a single CR LF.
    task automatic test_short_lines();
        write_line_len(10'd4);
        send_beat(8'h01, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'h7F, 1'b1);
        write_line_len(10'd0);
        send_random_stream(4);
        write_line_len(10'd3);
        send_random_stream(3);
        write_line_len(10'd8);
        send_random_stream(6);
    endtask

    // At the top of the line length range groups pile up on one line and only the
    // end of the stream breaks it.
    task automatic test_long_lines();
        write_line_len(10'd1023);
        send_random_stream(30);
        write_line_len(10'd1020);
        send_random_stream(18);
    endtask

    task automatic test_random_streams(input int tx_pct, input int rx_pct, input int n_bytes);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(99) < 30)
                write_line_len($urandom_range(1) ? 10'($urandom_range(1023))
                                                 : 10'($urandom_range(24)));
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_random_stream(len);
            sent += len;
        end
    endtask

    // The receiver holds off long enough for the queue to fill and stall the input.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_line_len(10'd12);
        rx_hold_left = HOLD_CYCLES;
        send_random_stream(40);
        wait_drain();
        send_random_stream(7);
    endtask

    // Result side: random stalls, and a long hold-off counted here when requested.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        enc_char_t e;
        if (rst_n && pop && !empty)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character beat: out_char %h", out_char);
                fail_count++;
            end
            else
            begin
                e = pending_chars.pop_front();
                if (out_char !== e.ch)
                begin
                    $error("out_char mismatch: expected %h, got %h", e.ch, out_char);
                    fail_count++;
                end
                if (last_of_run !== e.run_end)
                begin
                    $error("last_of_run mismatch: expected %b, got %b",
                           e.run_end, last_of_run);
                    fail_count++;
                end
                if (stream_done !== e.stream_end)
                begin
                    $error("stream_done mismatch: expected %b, got %b",
                           e.stream_end, stream_done);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("base64_line_wrapped_encoder_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        line_len_m = LINE_LEN_RESET;
        held_buf = '0;
        held_cnt = '0;
        grp_cnt = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_groups();
        test_short_lines();
        test_long_lines();
        test_random_streams(0, 0, 20);
        test_random_streams(54, 0, 20);
        test_random_streams(0, 54, 20);
        test_random_streams(14, 14, 20);
        test_backpressure();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", pending_chars.size());
            fail_count++;
        end
        $display("Covered %0d bytes in %0d streams, %0d characters checked,",
                 bytes_sent, streams_sent, chars_checked);
        $display("over line lengths 0 to 1023, random stalls and a full-queue hold-off.");
        if (fail_count == 0)
            $display("base64_line_wrapped_encoder_core verification clean");
        else
            $display("base64_line_wrapped_encoder_core verification failed");
        $finish;
    end

endmodule
